>>> sv/pps_pkg.sv
package pps_pkg;

    localparam int PROCS = 16;
    localparam int IDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int CNT_W = $clog2(PROCS + 1);

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int PID_W  = 5;
    localparam int TICK_W = 21;
    localparam int SUM_W  = 25;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 120;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_run;
        logic tick;
        logic diff;
        logic emit;
        logic clear_run;
    } pps_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic found;
        logic last_run;
        logic last_finish;
        logic out_free;
    } pps_sts_t;

endpackage

>>> sv/pps_ctrl.sv
module pps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  pps_pkg::pps_sts_t sts,
    output pps_pkg::pps_cmd_t cmd
);
    import pps_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TICK = 5'b00100,
        ST_DIFF = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (!sts.scan_busy) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                cmd.tick = 1'b1;
                if (sts.found && sts.last_run) begin
                    state_next = ST_DIFF;
                end else begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_finish) begin
                        cmd.clear_run = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> sv/pps_datapath.sv
module pps_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pps_pkg::pps_cmd_t                cmd,
    output pps_pkg::pps_sts_t                sts,
    // arrival_time, burst_length, priority_level
    input  logic [pps_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // process_id, completion_time, turnaround, waiting, waiting_total,
    // turnaround_total, zero fill
    output logic [pps_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast
);
    import pps_pkg::*;

    logic [ARR_W-1:0] arr_mem [PROCS];
    logic [BUR_W-1:0] bur_mem [PROCS];
    logic [PRI_W-1:0] pri_mem [PROCS];
    logic [BUR_W-1:0] rem_mem [PROCS];

    logic [CNT_W-1:0]  loaded_reg, finished_reg, scan_idx_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [SUM_W-1:0]  sum_w_reg, sum_t_reg;

    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ARR_W-1:0]  rd_arr_reg;
    logic [BUR_W-1:0]  rd_bur_reg;
    logic [PRI_W-1:0]  rd_pri_reg;
    logic [BUR_W-1:0]  rd_rem_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ARR_W-1:0]  best_arr_reg;
    logic [BUR_W-1:0]  best_bur_reg;
    logic [PRI_W-1:0]  best_pri_reg;
    logic [BUR_W-1:0]  best_rem_reg;

    logic [TICK_W-1:0] tat_reg, wt_reg;

    logic              out_valid_reg;
    logic              out_last_reg;
    logic [PID_W-1:0]  out_pid_reg;
    logic [TICK_W-1:0] out_ct_reg, out_tat_reg, out_wt_reg;
    logic [SUM_W-1:0]  out_sw_reg, out_st_reg;

    logic [ARR_W-1:0]  in_arr;
    logic [BUR_W-1:0]  in_bur;
    logic [PRI_W-1:0]  in_pri;
    logic              room;
    logic              issue;
    logic              better;
    logic [TICK_W-1:0] tick_next;
    logic [SUM_W-1:0]  sum_w_next, sum_t_next;
    logic [CNT_W-1:0]  finished_next;

    assign in_arr = s_tdata[ARR_W-1:0];
    assign in_bur = (s_tdata[ARR_W+BUR_W-1:ARR_W] == '0) ? BUR_W'(1)
                                                          : s_tdata[ARR_W+BUR_W-1:ARR_W];
    assign in_pri = s_tdata[ARR_W+BUR_W+PRI_W-1:ARR_W+BUR_W];
    assign room   = (loaded_reg < CNT_W'(PROCS));
    assign issue  = cmd.scan_run && (scan_idx_reg < loaded_reg);
    assign better = rd_valid_reg && (rd_rem_reg != '0)
                    && (TICK_W'(rd_arr_reg) <= tick_reg)
                    && (!found_reg || (rd_pri_reg < best_pri_reg));
    assign tick_next     = tick_reg + TICK_W'(1);
    assign sum_w_next    = sum_w_reg + SUM_W'(wt_reg);
    assign sum_t_next    = sum_t_reg + SUM_W'(tat_reg);
    assign finished_next = finished_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.load && room) begin
            arr_mem[loaded_reg[IDX_W-1:0]] <= in_arr;
            bur_mem[loaded_reg[IDX_W-1:0]] <= in_bur;
            pri_mem[loaded_reg[IDX_W-1:0]] <= in_pri;
        end
        if (cmd.load && room) begin
            rem_mem[loaded_reg[IDX_W-1:0]] <= in_bur;
        end else if (cmd.tick && found_reg) begin
            rem_mem[best_idx_reg] <= best_rem_reg - BUR_W'(1);
        end
        if (issue) begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
            rd_arr_reg <= arr_mem[scan_idx_reg[IDX_W-1:0]];
            rd_bur_reg <= bur_mem[scan_idx_reg[IDX_W-1:0]];
            rd_pri_reg <= pri_mem[scan_idx_reg[IDX_W-1:0]];
            rd_rem_reg <= rem_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (better) begin
            best_idx_reg <= rd_idx_reg;
            best_arr_reg <= rd_arr_reg;
            best_bur_reg <= rd_bur_reg;
            best_pri_reg <= rd_pri_reg;
            best_rem_reg <= rd_rem_reg;
        end
        if (cmd.tick) begin
            tat_reg <= tick_next - TICK_W'(best_arr_reg);
        end
        if (cmd.diff) begin
            wt_reg <= tat_reg - TICK_W'(best_bur_reg);
        end
        if (cmd.emit) begin
            out_pid_reg <= PID_W'(best_idx_reg) + PID_W'(1);
            out_ct_reg  <= tick_reg;
            out_tat_reg <= tat_reg;
            out_wt_reg  <= wt_reg;
            out_sw_reg  <= sum_w_next;
            out_st_reg  <= sum_t_next;
            out_last_reg <= (finished_next == loaded_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg    <= '0;
            finished_reg  <= '0;
            tick_reg      <= '0;
            sum_w_reg     <= '0;
            sum_t_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && room) begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.scan_clear) begin
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end else begin
                rd_valid_reg <= issue;
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (better) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.tick) begin
                tick_reg <= tick_next;
            end
            if (cmd.emit) begin
                finished_reg <= finished_next;
                sum_w_reg    <= sum_w_next;
                sum_t_reg    <= sum_t_next;
            end
            if (cmd.clear_run) begin
                loaded_reg   <= '0;
                finished_reg <= '0;
                tick_reg     <= '0;
                sum_w_reg    <= '0;
                sum_t_reg    <= '0;
                found_reg    <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.scan_busy   = (scan_idx_reg < loaded_reg) || rd_valid_reg;
    assign sts.found       = found_reg;
    assign sts.last_run    = (best_rem_reg == BUR_W'(1));
    assign sts.last_finish = (finished_next == loaded_reg);
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_st_reg, out_sw_reg, out_wt_reg, out_tat_reg,
                       out_ct_reg, out_pid_reg};

    a_finished_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg <= loaded_reg)
        else $error("More processes finished than were loaded.");

    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNT_W'(PROCS))
        else $error("Load count exceeds table depth.");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (CNT_W'(rd_idx_reg) < loaded_reg))
        else $error("Scan read beyond the loaded entries.");

    a_emit_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (found_reg && (best_rem_reg == BUR_W'(1))))
        else $error("Result word sent without a finishing tick.");

endmodule

>>> sv/preemptive_priority_scheduler.sv
// Loading takes one input word per cycle; the word with tlast starts scheduling.
// Each simulated tick scans the N loaded processes in the SCAN state, then steps in TICK:
// the scan reads one table entry per cycle through a registered memory port.
// A finishing tick also passes DIFF and EMIT, and EMIT waits out any stall on the result side.
// The next set is accepted once the last result word has been handed to the output register.
// Reset (aresetn low, synchronous) empties the set, clears tick and sums; tables are not cleared.
module preemptive_priority_scheduler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // arrival_time, burst_length, priority_level
    input  logic [pps_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // process_id, completion_time, turnaround, waiting, waiting_total,
    // turnaround_total, zero fill
    output logic [pps_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import pps_pkg::*;

    pps_cmd_t cmd;
    pps_sts_t sts;

    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pps_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int PROCS = pps_pkg::PROCS;

    typedef struct {
        logic [pps_pkg::PID_W-1:0]  pid;
        logic [pps_pkg::TICK_W-1:0] done_tick;
        logic [pps_pkg::TICK_W-1:0] tat;
        logic [pps_pkg::TICK_W-1:0] wait_ticks;
        logic [pps_pkg::SUM_W-1:0]  wait_sum;
        logic [pps_pkg::SUM_W-1:0]  tat_sum;
        logic                       last_done;
    } finish_rec_t;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pps_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                         s_tlast = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pps_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tlast;

    // Scheduler shadow state.
    logic [pps_pkg::ARR_W-1:0]  sched_arrival [PROCS];
    logic [pps_pkg::BUR_W-1:0]  sched_burst [PROCS];
    logic [pps_pkg::PRI_W-1:0]  sched_prio [PROCS];
    logic [pps_pkg::BUR_W-1:0]  sched_left [PROCS];
    int                         sched_loaded = 0;
    int                         sched_done = 0;
    logic [pps_pkg::TICK_W-1:0] sched_now = '0;
    logic [pps_pkg::SUM_W-1:0]  sum_wait = '0;
    logic [pps_pkg::SUM_W-1:0]  sum_tat = '0;

    finish_rec_t finishes_due[$];

    int err_count = 0;
    int words_sent = 0;
    int sets_run = 0;
    int finishes_checked = 0;
    int burst_left = 8;
    int rx_cycle = 0;

    preemptive_priority_scheduler DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(30_000_000);
        $display("tb: timeout with %0d finish records outstanding", finishes_due.size());
        $display("tb: failure");
        $finish;
    end

    // Stores one process word while the table has room and, on the closing word, plays out the whole set.
    task automatic schedule_word(input logic [15:0] arr, input logic [15:0] bur,
                                 input logic [7:0] pri, input logic last);
        int          pick;
        bit          found;
        finish_rec_t rec;
        if (sched_loaded < PROCS) begin
            sched_arrival[sched_loaded] = arr;
            sched_burst[sched_loaded]   = (bur == 0) ? 16'd1 : bur;
            sched_left[sched_loaded]    = (bur == 0) ? 16'd1 : bur;
            sched_prio[sched_loaded]    = pri;
            sched_loaded++;
        end
        if (!last) return;
        while (sched_done < sched_loaded) begin
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < sched_loaded; i++) begin
                if (sched_left[i] != 0 && sched_arrival[i] <= sched_now &&
                    (!found || sched_prio[i] < sched_prio[pick])) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            sched_now = sched_now + 1'b1;
            if (found) begin
                sched_left[pick] = sched_left[pick] - 1'b1;
                if (sched_left[pick] == 0) begin
                    rec.pid        = pps_pkg::PID_W'(pick + 1);
                    rec.done_tick  = sched_now;
                    rec.tat        = sched_now - pps_pkg::TICK_W'(sched_arrival[pick]);
                    rec.wait_ticks = rec.tat - pps_pkg::TICK_W'(sched_burst[pick]);
                    sum_wait       = sum_wait + pps_pkg::SUM_W'(rec.wait_ticks);
                    sum_tat        = sum_tat + pps_pkg::SUM_W'(rec.tat);
                    rec.wait_sum   = sum_wait;
                    rec.tat_sum    = sum_tat;
                    sched_done++;
                    rec.last_done  = (sched_done == sched_loaded);
                    finishes_due.push_back(rec);
                end
            end
        end
        sched_loaded = 0;
        sched_done   = 0;
        sched_now    = '0;
        sum_wait     = '0;
        sum_tat      = '0;
    endtask

    task automatic send_word(input logic [15:0] arr, input logic [15:0] bur,
                             input logic [7:0] pri, input logic last);
        s_tdata  <= {pri, bur, arr};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (last) sets_run++;
        schedule_word(arr, bur, pri, last);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (finishes_due.size() != 0);
    endtask

    task automatic test_single_process();
        send_word(16'd3, 16'd5, 8'd7, 1'b1);
        wait_drained();
    endtask

    // All-ones arrival and burst, both priority extremes.
    task automatic test_field_extremes();
        send_word(16'd0, 16'hFFFF, 8'hFF, 1'b0);
        send_word(16'hFFFF, 16'd1, 8'h00, 1'b1);
        wait_drained();
    endtask

    // Eighteen words into sixteen slots: the last two are dropped, the final one
    // still starts scheduling. Zero bursts and equal priorities are mixed in.
    task automatic test_full_table();
        for (int i = 0; i < PROCS + 2; i++) begin
            send_word(16'((i * 3) % 11), 16'(i % 5), 8'(i % 3), i == PROCS + 1);
        end
        wait_drained();
    endtask

    // A later arrival preempts a running process, and an idle stretch precedes
    // the last process.
    task automatic test_preemption();
        send_word(16'd2, 16'd6, 8'd9, 1'b0);
        send_word(16'd4, 16'd2, 8'd1, 1'b0);
        send_word(16'd4, 16'd3, 8'd1, 1'b0);
        send_word(16'd30, 16'd1, 8'd0, 1'b1);
    endtask

    task automatic test_random_sets();
        int target;
        int n;
        int pri_top;
        int arr_top;
        target = words_sent + 400;
        while (words_sent < target) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(PROCS + 1, PROCS + 3)
                                            : $urandom_range(1, PROCS);
            pri_top = ($urandom_range(0, 1) == 0) ? 3 : 255;
            arr_top = ($urandom_range(0, 3) == 0) ? 200 : 40;
            for (int i = 0; i < n; i++) begin
                send_word(16'($urandom_range(0, arr_top)), 16'($urandom_range(0, 12)),
                          8'($urandom_range(0, pri_top)), i == n - 1);
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        finish_rec_t seen;
        finish_rec_t due;
        int          mode;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            mode = (rx_cycle >> 7) & 3;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ((rx_cycle & 15) == 0);
                default: m_tready <= $urandom_range(0, 1);
            endcase
            if (m_tvalid && m_tready) begin
                seen.pid        = m_tdata[4:0];
                seen.done_tick  = m_tdata[25:5];
                seen.tat        = m_tdata[46:26];
                seen.wait_ticks = m_tdata[67:47];
                seen.wait_sum   = m_tdata[92:68];
                seen.tat_sum    = m_tdata[117:93];
                seen.last_done  = m_tlast;
                if (finishes_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("tb: unexpected finish word for process %0d at %0t",
                                 seen.pid, $realtime);
                end else begin
                    due = finishes_due.pop_front();
                    finishes_checked++;
                    if (seen.pid !== due.pid || seen.done_tick !== due.done_tick ||
                        seen.tat !== due.tat || seen.wait_ticks !== due.wait_ticks ||
                        seen.wait_sum !== due.wait_sum || seen.tat_sum !== due.tat_sum ||
                        seen.last_done !== due.last_done) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("tb: mismatch at %0t (id, done, tat, wait, wsum, tsum, last)",
                                     $realtime);
                            $display("    expected %0d %0d %0d %0d %0d %0d %0d", due.pid,
                                     due.done_tick, due.tat, due.wait_ticks, due.wait_sum,
                                     due.tat_sum, due.last_done);
                            $display("    actual   %0d %0d %0d %0d %0d %0d %0d", seen.pid,
                                     seen.done_tick, seen.tat, seen.wait_ticks, seen.wait_sum,
                                     seen.tat_sum, seen.last_done);
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_process();
        test_field_extremes();
        test_full_table();
        test_preemption();
        test_random_sets();
        wait_drained();
        repeat (64) @(posedge aclk);
        $display("tb: %0d sets scheduled from %0d process words, %0d finish words checked",
                 sets_run, words_sent, finishes_checked);
        $display("tb: covered full tables, zero bursts, ties, preemption, idle ticks, max fields");
        if (finishes_due.size() != 0)
            $display("tb: %0d finish words never arrived", finishes_due.size());
        if (err_count == 0 && finishes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
